@@ rtl/wavetable_oscillator_interp_assert.svh @@
// ----------------------------------------------------------------------------
// Wavetable oscillator assertion macros
// Clocked assertion shorthands for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_INTERP_ASSERT_SVH
`define WAVETABLE_OSCILLATOR_INTERP_ASSERT_SVH

// Check on every rising edge outside reset
`define WTOSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every rising edge, reset included
`define WTOSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/wtosc_pkg.sv @@
// ----------------------------------------------------------------------------
// Wavetable oscillator package
// Widths, register codes, the queued frame type, the quarter-wave sine tables
// and the waveform generator shared by the oscillator modules.
// ----------------------------------------------------------------------------
package wtosc_pkg;

  localparam int unsigned IDX_BITS    = 10;
  localparam int unsigned TABLE_SIZE  = 1 << IDX_BITS;
  localparam int unsigned QUARTER     = TABLE_SIZE / 4;
  localparam int unsigned FRAC_BITS   = 22;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned PHASE_W     = IDX_BITS + FRAC_BITS;
  localparam int unsigned STEP_W      = 32;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned SINE_BITS   = 15;
  localparam int unsigned SAW_SHIFT   = SAMPLE_BITS - IDX_BITS;
  localparam int unsigned TRI_SHIFT   = SAW_SHIFT + 1;
  localparam int unsigned SINE_SHIFT  = SAMPLE_BITS - 16;

  // back end stages from queue head to output register
  localparam int unsigned BACK_STAGES        = 4;
  localparam int unsigned FIFO_DEPTH_DEFAULT = 2;

  localparam logic [STEP_W-1:0] STEP_RESET  = 32'd19685267;
  localparam longint unsigned   PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE     = 2'd0,
    CFG_WAVEFORM   = 2'd1,
    CFG_PHASE_STEP = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_TRI    = 2'd2,
    WAVE_SQUARE = 2'd3
  } wave_e;

  typedef logic signed [SAMPLE_BITS-1:0]           sample_t;
  typedef logic signed [SAMPLE_BITS:0]             wave_t;
  typedef logic signed [SAMPLE_BITS+1:0]           diff_t;
  typedef logic signed [SAMPLE_BITS+FRAC_BITS+2:0] prod_t;
  typedef logic [IDX_BITS-1:0]                     idx_t;
  typedef logic [FRAC_BITS-1:0]                    frac_t;
  typedef logic [SINE_BITS-1:0]                    quarter_t [QUARTER];

  // One classified frame waiting for the back end
  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    osc_en;
    wave_e   wave;
    idx_t    idx;
    frac_t   frac;
  } item_t;

  localparam wave_t WAVE_ONE     = wave_t'(1) <<< (SAMPLE_BITS - 1);
  localparam wave_t WAVE_SAW_OFS = wave_t'(TABLE_SIZE / 2 - 1);
  localparam wave_t WAVE_QUARTER = wave_t'(QUARTER);
  localparam wave_t WAVE_3QUART  = wave_t'(3 * QUARTER);

  // Q15 sine of a Q30 angle in [0, pi/2], Taylor series to the 15th power
  function automatic logic [SINE_BITS-1:0] sin_q15(longint unsigned a);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned r;
    x2   = (a * a) >> 30;
    term = a;
    sum  = longint'(a);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      return '0;
    end
    r = (longint'(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[SINE_BITS-1:0];
  endfunction

  // Build one quarter of the sine magnitude, rising or falling
  function automatic quarter_t sine_quarter(logic falling);
    quarter_t        q;
    longint unsigned a;
    for (int j = 0; j < QUARTER; j++) begin
      a = (PI_HALF_Q30 * longint'(j)) >> (IDX_BITS - 2);
      q[j] = falling ? sin_q15(PI_HALF_Q30 - a) : sin_q15(a);
    end
    return q;
  endfunction

  localparam quarter_t SINE_RISE = sine_quarter(1'b0);
  localparam quarter_t SINE_FALL = sine_quarter(1'b1);

  // Oscillator value at table entry i, Q1.(SAMPLE_BITS-1) in SAMPLE_BITS+1 bits
  function automatic wave_t wave_value(wave_e sel, idx_t i);
    logic [1:0]           quad;
    logic [SINE_BITS-1:0] mag;
    wave_t                iw;
    wave_t                w;
    quad = i[IDX_BITS-1 -: 2];
    iw   = wave_t'(i);
    mag  = quad[0] ? SINE_FALL[i[IDX_BITS-3:0]] : SINE_RISE[i[IDX_BITS-3:0]];
    case (sel)
      WAVE_SINE: begin
        w = wave_t'(mag) <<< SINE_SHIFT;
        if (quad[1]) begin
          w = -w;
        end
      end
      WAVE_SAW: begin
        if (!quad[1]) begin
          w = iw <<< SAW_SHIFT;
        end else begin
          w = ((iw - WAVE_SAW_OFS) <<< SAW_SHIFT) - WAVE_ONE;
        end
      end
      WAVE_TRI: begin
        if (quad == 2'b00) begin
          w = iw <<< TRI_SHIFT;
        end else if (quad == 2'b11) begin
          w = ((iw - WAVE_3QUART) <<< TRI_SHIFT) - WAVE_ONE;
        end else begin
          w = WAVE_ONE - ((iw - WAVE_QUARTER) <<< TRI_SHIFT);
        end
      end
      WAVE_SQUARE: begin
        w = quad[1] ? -WAVE_ONE : WAVE_ONE;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/wtosc_front.sv @@
// ----------------------------------------------------------------------------
// Wavetable oscillator front end
// Holds the configuration registers and the phase accumulator, tags each
// accepted frame with its table index, fraction and waveform.
// ----------------------------------------------------------------------------
module wtosc_front
  import wtosc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sample_t               in_left_i,
  input  sample_t               in_right_i,
  output logic                  item_valid_o,
  input  logic                  item_ready_i,
  output item_t                 item_o
);

  logic               enable_q, enable_d;
  wave_e              wave_q, wave_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               accept;

  // Pass the beat straight into the queue
  assign in_ready_o   = item_ready_i;
  assign item_valid_o = in_valid_i;
  assign accept       = in_valid_i && item_ready_i;

  // Classify the frame at the current phase
  always_comb begin
    item_o.left   = in_left_i;
    item_o.right  = in_right_i;
    item_o.osc_en = enable_q;
    item_o.wave   = wave_q;
    item_o.idx    = phase_q[PHASE_W-1:FRAC_BITS];
    item_o.frac   = phase_q[FRAC_BITS-1:0];
  end

  // Decode register writes, advance the phase on enabled frames
  always_comb begin
    enable_d = enable_q;
    wave_d   = wave_q;
    step_d   = step_q;
    phase_d  = phase_q;
    if (accept && enable_q) begin
      phase_d = phase_q + PHASE_W'(step_q);
    end
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ENABLE: begin
          enable_d = cfg_wdata_i[0];
        end
        CFG_WAVEFORM: begin
          wave_d = wave_e'(cfg_wdata_i[1:0]);
        end
        CFG_PHASE_STEP: begin
          step_d  = STEP_W'(cfg_wdata_i);
          phase_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      wave_q   <= WAVE_SINE;
      step_q   <= STEP_RESET;
      phase_q  <= '0;
    end else begin
      enable_q <= enable_d;
      wave_q   <= wave_d;
      step_q   <= step_d;
      phase_q  <= phase_d;
    end
  end

endmodule

@@ rtl/wtosc_fifo.sv @@
// ----------------------------------------------------------------------------
// Wavetable oscillator frame queue
// Short register queue between the front and back ends so that each side
// stalls on its own.
// ----------------------------------------------------------------------------
module wtosc_fifo
  import wtosc_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers with wrap, track the fill level
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Store the pushed frame
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/wtosc_back.sv @@
// ----------------------------------------------------------------------------
// Wavetable oscillator back end
// Four-stage pipeline: waveform lookup, interpolation multiply, rounding,
// saturating mix into both channels. The whole pipe holds while the output
// register waits.
// ----------------------------------------------------------------------------
module wtosc_back
  import wtosc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    head_valid_i,
  output logic    head_ready_o,
  input  item_t   head_item_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output sample_t out_left_o,
  output sample_t out_right_o
);

  typedef logic signed [SAMPLE_BITS+1:0] mix_t;

  localparam prod_t PROD_HALF = prod_t'(1) <<< (FRAC_BITS - 1);
  localparam mix_t  MIX_MAX   = mix_t'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam mix_t  MIX_MIN   = -mix_t'(1 << (SAMPLE_BITS - 1));

  // Clamp a mixed sum to the sample range
  function automatic sample_t saturate(mix_t v);
    sample_t s;
    if (v > MIX_MAX) begin
      s = MIX_MAX[SAMPLE_BITS-1:0];
    end else if (v < MIX_MIN) begin
      s = MIX_MIN[SAMPLE_BITS-1:0];
    end else begin
      s = v[SAMPLE_BITS-1:0];
    end
    return s;
  endfunction

  logic    advance;
  wave_t   w0, w1;
  diff_t   d;
  prod_t   s3_sum;

  logic    s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  wave_t   s1_w0_q, s2_w0_q, s3_osc_q;
  diff_t   s1_d_q;
  frac_t   s1_frac_q;
  prod_t   s2_prod_q;
  sample_t s1_left_q, s2_left_q, s3_left_q, out_left_q;
  sample_t s1_right_q, s2_right_q, s3_right_q, out_right_q;

  // Hold everything while the output beat waits
  assign advance      = !out_valid_q || out_ready_i;
  assign head_ready_o = advance;
  assign out_valid_o  = out_valid_q;
  assign out_left_o   = out_left_q;
  assign out_right_o  = out_right_q;

  // Look up both neighbor entries; zero them for pass-through frames
  always_comb begin
    w0 = wave_value(head_item_i.wave, head_item_i.idx);
    w1 = wave_value(head_item_i.wave, IDX_BITS'(head_item_i.idx + 1'b1));
    d  = diff_t'(w1) - diff_t'(w0);
    if (!head_item_i.osc_en) begin
      w0 = '0;
      d  = '0;
    end
  end

  // Round: w0 * 2^F + d * f + half, then drop the fraction
  assign s3_sum = s2_prod_q + ((prod_t'(s2_w0_q) <<< FRAC_BITS) | PROD_HALF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= head_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      // lookup stage
      s1_w0_q    <= w0;
      s1_d_q     <= d;
      s1_frac_q  <= head_item_i.frac;
      s1_left_q  <= head_item_i.left;
      s1_right_q <= head_item_i.right;
      // multiply stage
      s2_prod_q  <= prod_t'(s1_d_q) * prod_t'($signed({1'b0, s1_frac_q}));
      s2_w0_q    <= s1_w0_q;
      s2_left_q  <= s1_left_q;
      s2_right_q <= s1_right_q;
      // rounding stage
      s3_osc_q   <= s3_sum[FRAC_BITS +: SAMPLE_BITS+1];
      s3_left_q  <= s2_left_q;
      s3_right_q <= s2_right_q;
      // mix stage
      out_left_q  <= saturate(mix_t'(s3_left_q) + mix_t'(s3_osc_q));
      out_right_q <= saturate(mix_t'(s3_right_q) + mix_t'(s3_osc_q));
    end
  end

endmodule

@@ rtl/wavetable_oscillator_interp.sv @@
// ----------------------------------------------------------------------------
// Wavetable oscillator with linear interpolation
// Mixes a sine, sawtooth, triangle or square oscillator into a stereo Q1.23
// frame stream with saturation.
//
//   Channel  Handshake               Payload
//   in       in_valid_i/in_ready_o   in_left_i, in_right_i
//   out      out_valid_o/out_ready_i out_left_o, out_right_o
//   cfg      cfg_we_i (no wait)      cfg_index_i, cfg_wdata_i
//
// One frame per cycle sustained while out_ready_i holds high; the output beat
// follows the input beat through one queue slot and the four back end stages.
// Reset clears the phase and valid state; config registers take their reset values.
// An output stall holds the back end; the queue then fills and drops in_ready_o.
// ----------------------------------------------------------------------------
module wavetable_oscillator_interp
  import wtosc_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sample_t               in_left_i,
  input  sample_t               in_right_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sample_t               out_left_o,
  output sample_t               out_right_o
);

  logic  front_valid, front_ready;
  item_t front_item;
  logic  head_valid, head_ready;
  item_t head_item;

  // Accept and tag frames
  wtosc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_left_i    (in_left_i),
    .in_right_i   (in_right_i),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready),
    .item_o       (front_item)
  );

  // Decouple front and back
  wtosc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_ready),
    .pop_item_o   (head_item)
  );

  // Interpolate and mix
  wtosc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_ready_o (head_ready),
    .head_item_i  (head_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_left_o   (out_left_o),
    .out_right_o  (out_right_o)
  );

endmodule

@@ rtl/wtosc_checker.sv @@
// ----------------------------------------------------------------------------
// Wavetable oscillator port checker
// Watches the top level ports: output beat hold, frame accounting and
// back pressure once the queue and pipeline are full.
// ----------------------------------------------------------------------------
`include "wavetable_oscillator_interp_assert.svh"

module wtosc_checker
  import wtosc_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_o,
  input logic    out_valid_o,
  input logic    out_ready_i,
  input sample_t out_left_o,
  input sample_t out_right_o
);

  localparam int unsigned MAX_PENDING = FIFO_DEPTH + BACK_STAGES;
  localparam int unsigned PEND_W      = $clog2(MAX_PENDING + 2);

  logic [PEND_W-1:0] pend_q, pend_d;
  logic              in_beat, out_beat;
  logic              out_stall;

  assign in_beat   = in_valid_i && in_ready_o;
  assign out_beat  = out_valid_o && out_ready_i;
  assign out_stall = out_valid_o && !out_ready_i;

  // Count frames accepted but not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (in_beat && !out_beat) begin
      pend_d = pend_q + 1'b1;
    end else if (out_beat && !in_beat) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `WTOSC_ASSERT(a_out_hold, out_stall |=> out_valid_o, "output beat dropped")
  `WTOSC_ASSERT(a_out_stable, out_stall |=> $stable({out_left_o, out_right_o}), "payload changed")
  `WTOSC_ASSERT(a_no_spurious, out_valid_o |-> pend_q != '0, "output beat without a frame")
  `WTOSC_ASSERT(a_backpressure, pend_q == PEND_W'(MAX_PENDING) |-> !in_ready_o, "ready while full")
  `WTOSC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind wavetable_oscillator_interp wtosc_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_wtosc_checker (.*);
